/* rtl/bleadv_pkg.sv */
// ----------------------------------------------------------------------------
// bleadv_pkg
// Shared types and constants for the advertising-data beacon parser.
// ----------------------------------------------------------------------------
package bleadv_pkg;

  // structure type and beacon layout
  localparam logic [7:0]  MFR_TYPE       = 8'hFF;
  localparam logic [15:0] BEACON_COMPANY = 16'h004C;
  localparam logic [7:0]  BEACON_SUBTYPE = 8'h02;
  localparam logic [7:0]  BEACON_SUBLEN  = 8'h15;
  localparam logic [7:0]  BEACON_MIN_LEN = 8'd26;
  localparam logic [7:0]  MFR_MIN_LEN    = 8'd3;

  // byte positions inside one structure (0 = length byte expected)
  localparam logic [7:0] POS_IDLE       = 8'd0;
  localparam logic [7:0] POS_TYPE       = 8'd1;
  localparam logic [7:0] POS_CO_LO      = 8'd2;
  localparam logic [7:0] POS_CO_HI      = 8'd3;
  localparam logic [7:0] POS_SUBTYPE    = 8'd4;
  localparam logic [7:0] POS_SUBLEN     = 8'd5;
  localparam logic [7:0] POS_UUID_FIRST = 8'd6;
  localparam logic [7:0] POS_UUID_SPLIT = 8'd14;
  localparam logic [7:0] POS_UUID_LAST  = 8'd21;
  localparam logic [7:0] POS_POWER      = 8'd26;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 160;

  typedef struct packed {
    logic signed [7:0] tx_power;
    logic [63:0]       uuid_lower;
    logic [63:0]       uuid_upper;
    logic              beacon_found;
    logic              company_valid;
    logic [15:0]       vendor_id;
  } result_t;

endpackage

/* rtl/ble_adv_data_beacon_parser_unit.sv */
// ----------------------------------------------------------------------------
// ble_adv_data_beacon_parser_unit
// Bluetooth LE advertising-data parser: company id and beacon UUID/power.
// ----------------------------------------------------------------------------
// One advertising-data record enters as a stream of bytes, one per input
// transaction, with tlast on the final byte. The block takes one byte every
// cycle. Each byte passes an input register, then the structure walker updates
// its state; on the last byte the result is loaded into the output register.
// Only a last byte can stall, and only while the output register still holds
// a result that has not been taken; other bytes keep flowing.
// Exactly one result transaction is produced per record.
module ble_adv_data_beacon_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bleadv_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                                 in_tlast,   // last_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] vendor_id, [16] company_valid, [17] beacon_found,
  // [81:18] uuid_upper, [145:82] uuid_lower, [153:146] tx_power, [159:154] 0
  output logic [bleadv_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import bleadv_pkg::*;

  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_free;
  logic                   proc_go;
  result_t                res;

  assign out_free  = !out_vld_r || out_tready;
  assign proc_go   = in_vld_r && (!in_last_r || out_free);
  assign in_tready = !in_vld_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
  end

  bleadv_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proc_go),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .result    (res)
  );

  assign out_data_nxt = {6'd0, res.tx_power, res.uuid_lower, res.uuid_upper,
                         res.beacon_found, res.company_valid, res.vendor_id};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_go && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // a finished record always lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && in_last_r) |=> out_vld_r)
    else $error("result not loaded after last byte");

  // a pending last byte never overwrites an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !(proc_go && in_last_r))
    else $error("result overwritten before it was taken");

  a_company_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[16] || out_data_r[15:0] == 16'd0))
    else $error("company id set without a complete manufacturer structure");

  a_beacon_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[17] || out_data_r[153:18] == 136'd0))
    else $error("beacon fields set without a match");

endmodule

/* rtl/bleadv_parse.sv */
// ----------------------------------------------------------------------------
// bleadv_parse
// Length-type-value walker: parser state, one byte per step, result on last.
// ----------------------------------------------------------------------------
module bleadv_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output bleadv_pkg::result_t result
);
  import bleadv_pkg::*;

  logic [7:0]  field_len_r,  field_len_nxt;
  logic [7:0]  field_pos_r,  field_pos_nxt;
  logic        mfr_field_r,  mfr_field_nxt;
  logic [15:0] pend_co_r,    pend_co_nxt;
  logic        prefix_ok_r,  prefix_ok_nxt;
  logic [63:0] uuid_hi_r,    uuid_hi_nxt;
  logic [63:0] uuid_lo_r,    uuid_lo_nxt;
  logic [7:0]  power_r,      power_nxt;
  logic [15:0] held_co_r,    held_co_nxt;
  logic        held_vld_r,   held_vld_nxt;
  logic        match_r,      match_nxt;
  logic        stopped_r,    stopped_nxt;

  always_comb begin
    field_len_nxt = field_len_r;
    field_pos_nxt = field_pos_r;
    mfr_field_nxt = mfr_field_r;
    pend_co_nxt   = pend_co_r;
    prefix_ok_nxt = prefix_ok_r;
    uuid_hi_nxt   = uuid_hi_r;
    uuid_lo_nxt   = uuid_lo_r;
    power_nxt     = power_r;
    held_co_nxt   = held_co_r;
    held_vld_nxt  = held_vld_r;
    match_nxt     = match_r;
    stopped_nxt   = stopped_r;

    if (!stopped_r) begin
      if (field_pos_r == POS_IDLE) begin
        // length byte; zero ends the record's useful content
        if (data_byte == 8'd0) begin
          stopped_nxt = 1'b1;
        end else begin
          field_len_nxt = data_byte;
          field_pos_nxt = POS_TYPE;
          mfr_field_nxt = 1'b0;
          prefix_ok_nxt = 1'b0;
          pend_co_nxt   = 16'd0;
        end
      end else begin
        if (field_pos_r == POS_TYPE) begin
          mfr_field_nxt = (data_byte == MFR_TYPE) && (field_len_r >= MFR_MIN_LEN);
        end else if (field_pos_r == POS_CO_LO) begin
          pend_co_nxt = {pend_co_r[15:8], data_byte};
        end else if (field_pos_r == POS_CO_HI) begin
          pend_co_nxt = {data_byte, pend_co_r[7:0]};
        end else if (field_pos_r == POS_SUBTYPE) begin
          prefix_ok_nxt = (data_byte == BEACON_SUBTYPE);
        end else if (field_pos_r == POS_SUBLEN) begin
          prefix_ok_nxt = prefix_ok_r && (data_byte == BEACON_SUBLEN);
        end else if (field_pos_r >= POS_UUID_FIRST && field_pos_r <= POS_UUID_LAST) begin
          if (field_pos_r < POS_UUID_SPLIT) begin
            uuid_hi_nxt = {uuid_hi_r[55:0], data_byte};
          end else begin
            uuid_lo_nxt = {uuid_lo_r[55:0], data_byte};
          end
        end else if (field_pos_r == POS_POWER) begin
          power_nxt = data_byte;
        end

        if (field_pos_r == field_len_r) begin
          // structure complete; a truncated one never gets here
          if (mfr_field_nxt) begin
            held_co_nxt  = pend_co_nxt;
            held_vld_nxt = 1'b1;
            if (pend_co_nxt == BEACON_COMPANY && field_len_r >= BEACON_MIN_LEN &&
                prefix_ok_nxt) begin
              match_nxt   = 1'b1;
              stopped_nxt = 1'b1;
            end
          end
          field_pos_nxt = POS_IDLE;
        end else begin
          field_pos_nxt = field_pos_r + 8'd1;
        end
      end
    end

    result.vendor_id     = held_vld_nxt ? held_co_nxt : 16'd0;
    result.company_valid = held_vld_nxt;
    result.beacon_found  = match_nxt;
    result.uuid_upper    = match_nxt ? uuid_hi_nxt : 64'd0;
    result.uuid_lower    = match_nxt ? uuid_lo_nxt : 64'd0;
    result.tx_power      = match_nxt ? power_nxt : 8'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      // record done: start clean for the next one
      field_len_r <= 8'd0;
      field_pos_r <= POS_IDLE;
      mfr_field_r <= 1'b0;
      pend_co_r   <= 16'd0;
      prefix_ok_r <= 1'b0;
      uuid_hi_r   <= 64'd0;
      uuid_lo_r   <= 64'd0;
      power_r     <= 8'd0;
      held_co_r   <= 16'd0;
      held_vld_r  <= 1'b0;
      match_r     <= 1'b0;
      stopped_r   <= 1'b0;
    end else if (step) begin
      field_len_r <= field_len_nxt;
      field_pos_r <= field_pos_nxt;
      mfr_field_r <= mfr_field_nxt;
      pend_co_r   <= pend_co_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      uuid_hi_r   <= uuid_hi_nxt;
      uuid_lo_r   <= uuid_lo_nxt;
      power_r     <= power_nxt;
      held_co_r   <= held_co_nxt;
      held_vld_r  <= held_vld_nxt;
      match_r     <= match_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the advertising-data beacon parser. Records are
// streamed byte by byte with random gaps. A byte-level structure walker predicts
// the result of each record, and every output transaction is compared field by
// field. The output side stalls at random, with two long hold-offs that back up
// the input.
// ----------------------------------------------------------------------------
module testbench;
  import bleadv_pkg::*;

  localparam int N_BYTES        = 1650;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } adv_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  ble_adv_data_beacon_parser_unit uut (.*);

  always #6 clk = ~clk;

  adv_byte_t  byte_feed[$];
  logic [7:0] rec_bytes[$];
  result_t    expected_reports[$];

  // structure walker state
  logic [7:0]  ltv_len, ltv_pos, pwr;
  logic        in_mfr, hdr_ok, co_seen, beacon_hit, walk_done;
  logic [15:0] co_pending, co_held;
  logic [63:0] uuid_hi, uuid_lo;

  int errors = 0;
  int bytes_in = 0;
  int records_in = 0;
  int reports_seen = 0;
  int beacons_expected = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    if (errors < 50)
      $display("MISMATCH result %0d %s: got %h expected %h", reports_seen, what, got, want);
    errors++;
  endtask

  task automatic reset_walker();
    ltv_len = '0;
    ltv_pos = POS_IDLE;
    in_mfr = 1'b0;
    hdr_ok = 1'b0;
    co_pending = '0;
    co_held = '0;
    co_seen = 1'b0;
    uuid_hi = '0;
    uuid_lo = '0;
    pwr = '0;
    beacon_hit = 1'b0;
    walk_done = 1'b0;
  endtask

  task automatic advance_walker(input adv_byte_t ab);
    logic [7:0] b, p;
    result_t    r;
    b = ab.data;
    p = ltv_pos;
    if (!walk_done) begin
      if (p == POS_IDLE) begin
        if (b == 8'd0) begin
          walk_done = 1'b1;
        end else begin
          ltv_len = b;
          ltv_pos = POS_TYPE;
          in_mfr = 1'b0;
          hdr_ok = 1'b0;
          co_pending = '0;
        end
      end else begin
        if (p == POS_TYPE) in_mfr = (b == MFR_TYPE) && (ltv_len >= MFR_MIN_LEN);
        else if (p == POS_CO_LO) co_pending[7:0] = b;
        else if (p == POS_CO_HI) co_pending[15:8] = b;
        else if (p == POS_SUBTYPE) hdr_ok = (b == BEACON_SUBTYPE);
        else if (p == POS_SUBLEN) hdr_ok = hdr_ok && (b == BEACON_SUBLEN);
        else if (p >= POS_UUID_FIRST && p <= POS_UUID_LAST) begin
          // uuid bytes shift in, earliest byte ends up most significant
          if (p < POS_UUID_SPLIT) uuid_hi = {uuid_hi[55:0], b};
          else uuid_lo = {uuid_lo[55:0], b};
        end else if (p == POS_POWER) pwr = b;

        if (p == ltv_len) begin
          if (in_mfr) begin
            co_held = co_pending;
            co_seen = 1'b1;
            if (co_pending == BEACON_COMPANY && ltv_len >= BEACON_MIN_LEN && hdr_ok) begin
              beacon_hit = 1'b1;
              walk_done = 1'b1;
            end
          end
          ltv_pos = POS_IDLE;
        end else begin
          ltv_pos = p + 8'd1;
        end
      end
    end
    if (ab.last) begin
      r = '0;
      r.company_valid = co_seen;
      r.vendor_id = co_seen ? co_held : 16'h0000;
      r.beacon_found = beacon_hit;
      if (beacon_hit) begin
        r.uuid_upper = uuid_hi;
        r.uuid_lower = uuid_lo;
        r.tx_power = pwr;
        beacons_expected++;
      end
      expected_reports.push_back(r);
      reset_walker();
    end
  endtask

  // ---- record building ----
  task automatic add_mfr(input int len, input logic [15:0] co, input logic [7:0] st,
                         input logic [7:0] sl, input logic [7:0] pw);
    logic [7:0] v;
    rec_bytes.push_back(len[7:0]);
    for (int p = 1; p <= len; p++) begin
      if (p == POS_TYPE) v = MFR_TYPE;
      else if (p == POS_CO_LO) v = co[7:0];
      else if (p == POS_CO_HI) v = co[15:8];
      else if (p == POS_SUBTYPE) v = st;
      else if (p == POS_SUBLEN) v = sl;
      else if (p == POS_POWER) v = pw;
      else v = 8'($urandom);
      rec_bytes.push_back(v);
    end
  endtask

  task automatic add_ltv(input int len, input logic [7:0] kind);
    rec_bytes.push_back(len[7:0]);
    if (len >= 1) rec_bytes.push_back(kind);
    for (int p = 2; p <= len; p++) rec_bytes.push_back(8'($urandom));
  endtask

  task automatic close_record();
    adv_byte_t ab;
    for (int i = 0; i < rec_bytes.size(); i++) begin
      ab.data = rec_bytes[i];
      ab.last = (i == rec_bytes.size() - 1);
      byte_feed.push_back(ab);
    end
    rec_bytes.delete();
    records_in++;
  endtask

  // ---- input driver ----
  always @(posedge clk) begin : driver
    logic      hold;
    adv_byte_t ab;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      hold = in_tvalid && !in_tready;
      if (in_tvalid && in_tready) begin
        ab.data = in_tdata;
        ab.last = in_tlast;
        advance_walker(ab);
        bytes_in++;
      end
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_feed.size() > 0) begin
          ab = byte_feed.pop_front();
          in_tdata <= ab.data;
          in_tlast <= ab.last;
          hold = 1'b1;
          if ($urandom_range(0, 24) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 13);
        end
      end
      in_tvalid <= hold;
    end
  end

  // ---- output monitor and ready control ----
  always @(posedge clk) begin : receiver
    result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        reports_seen++;
        if (expected_reports.size() == 0) begin
          log_mismatch("unexpected transaction", 64'd0, 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (got.vendor_id !== want.vendor_id)
            log_mismatch("vendor_id", 64'(got.vendor_id), 64'(want.vendor_id));
          if (got.company_valid !== want.company_valid)
            log_mismatch("company_valid", 64'(got.company_valid),
                         64'(want.company_valid));
          if (got.beacon_found !== want.beacon_found)
            log_mismatch("beacon_found", 64'(got.beacon_found), 64'(want.beacon_found));
          if (got.uuid_upper !== want.uuid_upper)
            log_mismatch("uuid_upper", got.uuid_upper, want.uuid_upper);
          if (got.uuid_lower !== want.uuid_lower)
            log_mismatch("uuid_lower", got.uuid_lower, want.uuid_lower);
          if (got.tx_power !== want.tx_power)
            log_mismatch("tx_power", 64'(got.tx_power), 64'(want.tx_power));
        end
        // long back-pressure so the last byte of later records stalls the input
        if (reports_seen == 15 || reports_seen == 50) hold_left = LONG_HOLD;
        if ($urandom_range(0, 24) == 0) recv_burst = !recv_burst;
        recv_gap = recv_burst ? 0 : $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding",
               cycle_count, expected_reports.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int kind, n, pick, cut, blen;
    reset_walker();

    // directed records
    rec_bytes.push_back(8'h00);                       // zero length only
    close_record();
    rec_bytes.push_back(8'h05);                       // length byte, nothing after
    close_record();
    rec_bytes.push_back(8'hFF);
    close_record();
    add_ltv(2, 8'h01);
    add_mfr(26, BEACON_COMPANY, BEACON_SUBTYPE, BEACON_SUBLEN, 8'hC5);
    close_record();
    add_mfr(26, BEACON_COMPANY, BEACON_SUBTYPE, BEACON_SUBLEN, 8'h7F);
    add_mfr(3, 16'h1234, 8'h00, 8'h00, 8'h00);        // ignored after match
    close_record();
    add_mfr(27, BEACON_COMPANY, BEACON_SUBTYPE, BEACON_SUBLEN, 8'h80);
    add_ltv(4, 8'h09);
    close_record();
    add_mfr(3, 16'h1234, 8'h00, 8'h00, 8'h00);
    close_record();
    add_mfr(2, 16'h0034, 8'h00, 8'h00, 8'h00);        // too short for a company
    add_mfr(3, 16'h5678, 8'h00, 8'h00, 8'h00);
    close_record();
    add_mfr(3, 16'h2211, 8'h00, 8'h00, 8'h00);
    add_mfr(4, 16'h4433, 8'h00, 8'h00, 8'h00);
    close_record();
    add_mfr(3, 16'h2211, 8'h00, 8'h00, 8'h00);
    rec_bytes.push_back(8'h00);
    add_mfr(3, 16'h4433, 8'h00, 8'h00, 8'h00);
    close_record();
    add_mfr(3, 16'hBBAA, 8'h00, 8'h00, 8'h00);
    add_mfr(26, BEACON_COMPANY, BEACON_SUBTYPE, BEACON_SUBLEN, 8'h10);
    repeat (12) void'(rec_bytes.pop_back());          // beacon cut by end of record
    close_record();
    add_mfr(26, BEACON_COMPANY, 8'h03, BEACON_SUBLEN, 8'h01);
    close_record();
    add_mfr(26, BEACON_COMPANY, BEACON_SUBTYPE, 8'h16, 8'h02);
    close_record();
    add_mfr(25, BEACON_COMPANY, BEACON_SUBTYPE, BEACON_SUBLEN, 8'h03);
    close_record();
    add_mfr(26, 16'h004D, BEACON_SUBTYPE, BEACON_SUBLEN, 8'h04);
    close_record();
    rec_bytes.push_back(8'hFF);
    rec_bytes.push_back(8'hFF);
    close_record();
    add_ltv(3, 8'hFE);
    close_record();
    add_mfr(1, 16'h0000, 8'h00, 8'h00, 8'h00);
    add_ltv(1, 8'h00);
    close_record();

    // random records, mostly well-formed structure chains
    while (byte_feed.size() < N_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) begin
            add_ltv(2, 8'h01);
          end else if (pick < 4) begin
            add_ltv($urandom_range(1, 12), 8'($urandom));
          end else if (pick < 6) begin
            add_mfr($urandom_range(1, 8),
                    ($urandom_range(0, 3) == 0) ? BEACON_COMPANY : 16'($urandom),
                    8'($urandom), 8'($urandom), 8'($urandom));
          end else begin
            blen = ($urandom_range(0, 5) == 0) ? $urandom_range(24, 30) : 26;
            add_mfr(blen,
                    ($urandom_range(0, 9) == 0) ? 16'($urandom) : BEACON_COMPANY,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom) : BEACON_SUBTYPE,
                    ($urandom_range(0, 9) == 0) ? 8'($urandom) : BEACON_SUBLEN,
                    8'($urandom));
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          rec_bytes.push_back(8'h00);
          add_mfr(3, 16'($urandom), 8'h00, 8'h00, 8'h00);
        end
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, 20);
          while (cut > 0 && rec_bytes.size() > 1) begin
            void'(rec_bytes.pop_back());
            cut--;
          end
        end
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 40)) rec_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          rec_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
      end
      close_record();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_feed.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d records (%0d bytes), %0d results checked, %0d beacon matches.",
             records_in, bytes_in, reports_seen, beacons_expected);
    $display("Output side held off twice for %0d cycles to back up the input.", LONG_HOLD);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
